### hw/rtl/cfet_pkg.sv
// shared types and constants for the coalescing free extent table
package cfet_pkg;

  localparam int LEN_W   = 32;
  localparam int END_W   = 33;
  localparam int FIELD_W = 32;
  localparam int STAT_W  = 3;
  localparam int USED_W  = 7;

  localparam logic OP_RELEASE = 1'b0;
  localparam logic OP_TAKE    = 1'b1;

  localparam logic [STAT_W-1:0] ST_NEW   = 3'd0;
  localparam logic [STAT_W-1:0] ST_BELOW = 3'd1;
  localparam logic [STAT_W-1:0] ST_ABOVE = 3'd2;
  localparam logic [STAT_W-1:0] ST_BOTH  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd4;
  localparam logic [STAT_W-1:0] ST_TAKEN = 3'd5;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_SEL,
    S_DEC,
    S_UPD
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INS_HI,
    CMD_INS_FRONT,
    CMD_BELOW,
    CMD_BOTH,
    CMD_ABOVE_HI,
    CMD_ABOVE_FRONT,
    CMD_TAKE
  } cmd_t;

  typedef struct packed {
    logic             v;
    logic [LEN_W-1:0] len;
    logic             lt;
    logic             lo;
    logic [LEN_W-1:0] lsum;
    logic [LEN_W-1:0] lsum2;
  } link_t;

  typedef struct packed {
    logic             lo_ee;
    logic             hi_eb;
    logic             hi_both;
    logic             eb;
    logic [LEN_W-1:0] lo_lsum;
    logic [LEN_W-1:0] hi_lsum;
    logic [LEN_W-1:0] hi_lsum2;
  } cstat_t;

  typedef struct packed {
    logic             cmp;
    logic             sel;
    logic             upd;
    cmd_t             cmd;
    logic [LEN_W-1:0] bl;
  } ctl_t;

endpackage

### hw/rtl/coalescing_free_extent_table_unit.sv
// top level of the coalescing free extent table
// Keeps up to TABLE_ENTRIES free extents sorted by start address in a row of
// cells, one extent per cell. Each beat goes through the idle state in which it is
// accepted, a compare pass in every cell, a pass where each cell looks at its
// neighbors to find the extents below and above, a decision step, and an update
// step where the whole row shifts or merges in place and the result is loaded into
// the output register. in_ready is high only while the block is idle; the next beat
// can be accepted while a result waits in the output register, but its update step
// stalls until that result is taken. No clearing pass is needed after reset.
module coalescing_free_extent_table_unit
  import cfet_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int ADDRESS_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [FIELD_W-1:0] in_block_start,
  input  logic [FIELD_W-1:0] in_block_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  out_status,
  output logic [FIELD_W-1:0] out_extent_start,
  output logic [FIELD_W-1:0] out_extent_length,
  output logic [USED_W-1:0]  out_entries_used
);

  localparam int SW = (ADDRESS_BITS < FIELD_W) ? ADDRESS_BITS : FIELD_W;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  state_t           state_r, state_nxt;
  logic             op_r;
  logic [SW-1:0]    bs_r;
  logic [LEN_W-1:0] bl_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [STAT_W-1:0] res_st_r;
  cmd_t             cmd_r;
  logic [SW-1:0]    res_start_r;
  logic [LEN_W-1:0] res_len_r;
  logic             out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [FIELD_W-1:0] out_start_r;
  logic [LEN_W-1:0] out_len_r;
  logic [USED_W-1:0] out_used_r;

  ctl_t             ctl;
  logic             out_free;

  link_t            link_a       [TABLE_ENTRIES];
  logic [SW-1:0]    start_a      [TABLE_ENTRIES];
  cstat_t           stat_a       [TABLE_ENTRIES];
  logic [SW-1:0]    lostart_a    [TABLE_ENTRIES];
  link_t            left_link_a  [TABLE_ENTRIES];
  logic [SW-1:0]    left_start_a [TABLE_ENTRIES];
  link_t            right_link_a [TABLE_ENTRIES];
  logic [SW-1:0]    right_start_a[TABLE_ENTRIES];

  logic             any_lo_ee, any_hi_eb, any_hi_both;
  logic [LEN_W-1:0] red_lo_lsum, red_hi_lsum, red_hi_lsum2;
  logic [SW-1:0]    red_lo_start;

  logic              empty, full, front;
  logic [STAT_W-1:0] dec_st;
  cmd_t              dec_cmd;
  logic [SW-1:0]     dec_start;
  logic [LEN_W-1:0]  dec_len;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : gen_cell
    if (i == 0) begin : gen_first
      assign left_link_a[i]  = '0;
      assign left_start_a[i] = '0;
    end else begin : gen_mid
      assign left_link_a[i]  = link_a[i-1];
      assign left_start_a[i] = start_a[i-1];
    end
    if (i == TABLE_ENTRIES - 1) begin : gen_last
      assign right_link_a[i]  = '0;
      assign right_start_a[i] = '0;
    end else begin : gen_inner
      assign right_link_a[i]  = link_a[i+1];
      assign right_start_a[i] = start_a[i+1];
    end

    cfet_cell #(
      .SW(SW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .head       (i == 0),
      .ctl        (ctl),
      .bs         (bs_r),
      .left_link  (left_link_a[i]),
      .left_start (left_start_a[i]),
      .right_link (right_link_a[i]),
      .right_start(right_start_a[i]),
      .link       (link_a[i]),
      .start      (start_a[i]),
      .stat       (stat_a[i]),
      .lo_start   (lostart_a[i])
    );
  end

  // pick up the flagged neighbors
  always_comb begin
    any_lo_ee    = 1'b0;
    any_hi_eb    = 1'b0;
    any_hi_both  = 1'b0;
    red_lo_lsum  = '0;
    red_hi_lsum  = '0;
    red_hi_lsum2 = '0;
    red_lo_start = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      any_lo_ee    = any_lo_ee | stat_a[i].lo_ee;
      any_hi_eb    = any_hi_eb | stat_a[i].hi_eb;
      any_hi_both  = any_hi_both | stat_a[i].hi_both;
      red_lo_lsum  = red_lo_lsum | stat_a[i].lo_lsum;
      red_hi_lsum  = red_hi_lsum | stat_a[i].hi_lsum;
      red_hi_lsum2 = red_hi_lsum2 | stat_a[i].hi_lsum2;
      red_lo_start = red_lo_start | lostart_a[i];
    end
  end

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_MAX);
  assign front = (bs_r < start_a[0]);

  always_comb begin
    dec_st    = ST_NEW;
    dec_cmd   = CMD_NONE;
    dec_start = bs_r;
    dec_len   = bl_r;
    if (op_r == OP_TAKE) begin
      if (empty) begin
        dec_st    = ST_EMPTY;
        dec_start = '0;
        dec_len   = '0;
      end else begin
        dec_st    = ST_TAKEN;
        dec_cmd   = CMD_TAKE;
        dec_start = start_a[0];
        dec_len   = link_a[0].len;
      end
    end else if (empty) begin
      dec_cmd = CMD_INS_FRONT;
    end else if (front) begin
      if (stat_a[0].eb) begin
        dec_st  = ST_ABOVE;
        dec_cmd = CMD_ABOVE_FRONT;
        dec_len = link_a[0].lsum;
      end else if (full) begin
        dec_st = ST_FULL;
      end else begin
        dec_cmd = CMD_INS_FRONT;
      end
    end else if (any_lo_ee) begin
      dec_start = red_lo_start;
      if (any_hi_both) begin
        dec_st  = ST_BOTH;
        dec_cmd = CMD_BOTH;
        dec_len = red_hi_lsum2;
      end else begin
        dec_st  = ST_BELOW;
        dec_cmd = CMD_BELOW;
        dec_len = red_lo_lsum;
      end
    end else if (any_hi_eb) begin
      dec_st  = ST_ABOVE;
      dec_cmd = CMD_ABOVE_HI;
      dec_len = red_hi_lsum;
    end else if (full) begin
      dec_st = ST_FULL;
    end else begin
      dec_cmd = CMD_INS_HI;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_SEL;
      S_SEL:   state_nxt = S_DEC;
      S_DEC:   state_nxt = S_UPD;
      S_UPD:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    ctl.cmp  = (state_r == S_CMP);
    ctl.sel  = (state_r == S_SEL);
    ctl.upd  = (state_r == S_UPD) && out_free;
    ctl.cmd  = cmd_r;
    ctl.bl   = bl_r;
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.upd) begin
      case (cmd_r)
        CMD_INS_HI, CMD_INS_FRONT: count_nxt = count_r + CNT_ONE;
        CMD_BOTH, CMD_TAKE:        count_nxt = count_r - CNT_ONE;
        default:                   count_nxt = count_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.upd) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= in_operation;
      bs_r <= in_block_start[SW-1:0];
      bl_r <= in_block_length;
    end
    if (state_r == S_DEC) begin
      res_st_r    <= dec_st;
      cmd_r       <= dec_cmd;
      res_start_r <= dec_start;
      res_len_r   <= dec_len;
    end
    if (ctl.upd) begin
      out_status_r <= res_st_r;
      out_start_r  <= FIELD_W'(res_start_r);
      out_len_r    <= res_len_r;
      out_used_r   <= USED_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_extent_start  = out_start_r;
  assign out_extent_length = out_len_r;
  assign out_entries_used  = out_used_r;

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("extent count above table size");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && res_st_r == ST_FULL) |-> (full && cmd_r == CMD_NONE))
    else $error("drop flagged while table not full");

  a_take_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.upd && cmd_r == CMD_TAKE) |=> (count_r == $past(count_r) - CNT_ONE))
    else $error("take did not remove one extent");
`endif

endmodule

### hw/rtl/cfet_cell.sv
// one table cell: holds one extent, compares it and shifts with its neighbors
module cfet_cell
  import cfet_pkg::*;
#(
  parameter int SW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head,
  input  ctl_t          ctl,
  input  logic [SW-1:0] bs,
  input  link_t         left_link,
  input  logic [SW-1:0] left_start,
  input  link_t         right_link,
  input  logic [SW-1:0] right_start,
  output link_t         link,
  output logic [SW-1:0] start,
  output cstat_t        stat,
  output logic [SW-1:0] lo_start
);

  localparam int EXT = END_W - SW;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? '1 : s[LEN_W-1:0];
  endfunction

  logic             v_r, v_nxt;
  logic [SW-1:0]    start_r, start_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             lt_r, ee_r, eb_r, lo_r, hi_r, hb_r;
  logic [LEN_W-1:0] lsum_r, lsum2_r;
  logic [END_W-1:0] own_end, blk_end, pair_end, bs_w, start_w;
  logic             lo_c;
  logic             geq;

  assign bs_w     = {{EXT{1'b0}}, bs};
  assign start_w  = {{EXT{1'b0}}, start_r};
  assign own_end  = start_w + END_W'(len_r);
  assign blk_end  = bs_w + END_W'(ctl.bl);
  assign pair_end = {{EXT{1'b0}}, left_start} + END_W'(left_link.lsum);

  // last extent starting below the released one, or the first one
  assign lo_c = (lt_r && !right_link.lt) || (head && !lt_r);
  assign geq  = !lt_r && !head;

  always_comb begin
    v_nxt     = v_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    if (ctl.upd) begin
      case (ctl.cmd)
        CMD_INS_HI: begin
          if (hi_r) begin
            v_nxt = 1'b1; start_nxt = bs; len_nxt = ctl.bl;
          end else if (geq) begin
            v_nxt = left_link.v; start_nxt = left_start; len_nxt = left_link.len;
          end
        end
        CMD_INS_FRONT: begin
          if (head) begin
            v_nxt = 1'b1; start_nxt = bs; len_nxt = ctl.bl;
          end else begin
            v_nxt = left_link.v; start_nxt = left_start; len_nxt = left_link.len;
          end
        end
        CMD_BELOW: begin
          if (lo_r) len_nxt = lsum_r;
        end
        CMD_BOTH: begin
          if (lo_r) begin
            len_nxt = right_link.lsum2;
          end else if (geq) begin
            v_nxt = right_link.v; start_nxt = right_start; len_nxt = right_link.len;
          end
        end
        CMD_ABOVE_HI: begin
          if (hi_r) begin
            start_nxt = bs; len_nxt = lsum_r;
          end
        end
        CMD_ABOVE_FRONT: begin
          if (head) begin
            start_nxt = bs; len_nxt = lsum_r;
          end
        end
        CMD_TAKE: begin
          v_nxt = right_link.v; start_nxt = right_start; len_nxt = right_link.len;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    len_r   <= len_nxt;
    if (ctl.cmp) begin
      lt_r   <= v_r && (start_r < bs);
      ee_r   <= v_r && (own_end == bs_w);
      eb_r   <= v_r && (start_w == blk_end);
      lsum_r <= sat_add(len_r, ctl.bl);
    end
    if (ctl.sel) begin
      lo_r    <= lo_c;
      hi_r    <= left_link.lo;
      hb_r    <= v_r && (pair_end == start_w);
      lsum2_r <= sat_add(left_link.lsum, len_r);
    end
  end

  assign link.v     = v_r;
  assign link.len   = len_r;
  assign link.lt    = lt_r;
  assign link.lo    = lo_c;
  assign link.lsum  = lsum_r;
  assign link.lsum2 = lsum2_r;
  assign start      = start_r;

  assign stat.lo_ee    = lo_r && ee_r;
  assign stat.hi_eb    = hi_r && eb_r;
  assign stat.hi_both  = hi_r && hb_r;
  assign stat.eb       = eb_r;
  assign stat.lo_lsum  = lo_r ? lsum_r : '0;
  assign stat.hi_lsum  = hi_r ? lsum_r : '0;
  assign stat.hi_lsum2 = hi_r ? lsum2_r : '0;
  assign lo_start      = lo_r ? start_r : '0;

`ifndef SYNTH
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && !head) |-> left_link.v)
    else $error("cell valid while left neighbor empty");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && left_link.v) |-> (left_start <= start_r))
    else $error("extent starts out of order");
`endif

endmodule
